[hw/rtl/image_bilinear_sampler_unit_macros.svh]
// Assertion macros shared by the sampler RTL
`ifndef IMAGE_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define IMAGE_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define IBS_ASSERT_IMPLY(label, clk, rst, cond, exp_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (exp_c)) \
      else $error("sampler check failed");

// next-cycle implication
`define IBS_ASSERT_NEXT(label, clk, rst, cond, exp_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (exp_c)) \
      else $error("sampler check failed");

`endif

[hw/rtl/ibs_pkg.sv]
package ibs_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int COORD_MAX_W = 12;
   localparam int FRAC_MAX_W  = 16;
   localparam int DIM_REG_W   = 9;
   localparam int DIM_RESET   = 256;
   localparam int CSR_INDEX_W = 1;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_BILINEAR = 2'd1;
   localparam logic [1:0] OP_NEAREST  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         pixel_col;
      logic [7:0]         pixel_row;
      logic [7:0]         pixel_value;
      logic signed [19:0] sample_x;
      logic signed [19:0] sample_y;
   } req_type;

   typedef struct packed {
      logic [15:0] sample_value;
      logic        in_range;
   } rsp_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [COORD_MAX_W-1:0] col;
      logic [COORD_MAX_W-1:0] row;
      logic [FRAC_MAX_W-1:0]  frac_x;
      logic [FRAC_MAX_W-1:0]  frac_y;
      logic                   col_last;
      logic                   row_last;
      logic                   in_range;
      logic                   store_hit;
      logic [7:0]             value;
   } entry_type;

endpackage

[hw/rtl/ibs_fifo.sv]
module ibs_fifo #(
   parameter int WIDTH = $bits(ibs_pkg::entry_type),
   parameter int DEPTH = ibs_pkg::MID_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push, do_pop;

   assign full     = level_ff == LW'(DEPTH);
   assign empty    = level_ff == '0;
   assign level    = level_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/ibs_front.sv]
module ibs_front #(
   parameter int MAX_WIDTH  = ibs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ibs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = ibs_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ibs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ibs_pkg::DIM_REG_W-1:0]      csr_data,
   input  ibs_pkg::req_type                   req,
   output ibs_pkg::entry_type                 entry,
   output logic                               entry_keep
);

   localparam int F   = FRAC_BITS;
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int DXW = $clog2(MAX_WIDTH + 1);
   localparam int DYW = $clog2(MAX_HEIGHT + 1);
   localparam int DW  = (DXW > DYW) ? DXW : DYW;
   localparam int CW  = (F + DW > 20) ? F + DW : 20;
   localparam int HW  = CW - F;
   localparam int CMW = ibs_pkg::COORD_MAX_W;
   localparam int FMW = ibs_pkg::FRAC_MAX_W;
   localparam int RST_W = (ibs_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : ibs_pkg::DIM_RESET;
   localparam int RST_H = (ibs_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : ibs_pkg::DIM_RESET;

   logic [DXW-1:0] w_eff_ff, w_eff_in, dim_x;
   logic [DYW-1:0] h_eff_ff, h_eff_in, dim_y;

   logic [CW-1:0] sx_e, sy_e, hi_x, hi_y;
   logic          neg_x, neg_y, over_x, over_y, near_x_ok, near_y_ok;
   logic [XW-1:0] last_col, x0_bil, x_near;
   logic [YW-1:0] last_row, y0_bil, y_near;
   logic [F-1:0]  fx_bil, fy_bil;

   always_comb begin
      dim_x = (csr_data == '0) ? DXW'(1) :
              ((32'(csr_data) > 32'(MAX_WIDTH)) ? DXW'(MAX_WIDTH) : DXW'(csr_data));
      dim_y = (csr_data == '0) ? DYW'(1) :
              ((32'(csr_data) > 32'(MAX_HEIGHT)) ? DYW'(MAX_HEIGHT) : DYW'(csr_data));
      w_eff_in = w_eff_ff;
      h_eff_in = h_eff_ff;
      if (csr_write) begin
         case (csr_index)
            ibs_pkg::CSR_IMAGE_WIDTH: begin
               w_eff_in = dim_x;
            end
            ibs_pkg::CSR_IMAGE_HEIGHT: begin
               h_eff_in = dim_y;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff <= DXW'(RST_W);
         h_eff_ff <= DYW'(RST_H);
      end else begin
         w_eff_ff <= w_eff_in;
         h_eff_ff <= h_eff_in;
      end
   end

   always_comb begin
      sx_e = CW'($signed(req.sample_x));
      sy_e = CW'($signed(req.sample_y));
      hi_x = CW'(w_eff_ff - 1'b1) << F;
      hi_y = CW'(h_eff_ff - 1'b1) << F;
      neg_x = sx_e[CW-1];
      neg_y = sy_e[CW-1];
      over_x = !neg_x && (sx_e > hi_x);
      over_y = !neg_y && (sy_e > hi_y);
      last_col = XW'(w_eff_ff - 1'b1);
      last_row = YW'(h_eff_ff - 1'b1);

      x0_bil = neg_x ? '0 : (over_x ? last_col : sx_e[F +: XW]);
      y0_bil = neg_y ? '0 : (over_y ? last_row : sy_e[F +: YW]);
      fx_bil = (neg_x || over_x) ? '0 : sx_e[F-1:0];
      fy_bil = (neg_y || over_y) ? '0 : sy_e[F-1:0];

      near_x_ok = neg_x ? ((&sx_e[CW-1:F]) && (|sx_e[F-1:0])) :
                          (sx_e[CW-1:F] < HW'(w_eff_ff));
      near_y_ok = neg_y ? ((&sy_e[CW-1:F]) && (|sy_e[F-1:0])) :
                          (sy_e[CW-1:F] < HW'(h_eff_ff));
      x_near = neg_x ? '0 : sx_e[F +: XW];
      y_near = neg_y ? '0 : sy_e[F +: YW];
   end

   always_comb begin
      entry      = '0;
      entry.kind = req.opcode;
      entry_keep = 1'b0;
      case (req.opcode)
         ibs_pkg::OP_WRITE: begin
            entry_keep      = 1'b1;
            entry.col       = CMW'(req.pixel_col);
            entry.row       = CMW'(req.pixel_row);
            entry.value     = req.pixel_value;
            entry.store_hit = (32'(req.pixel_col) < 32'(MAX_WIDTH)) &&
                              (32'(req.pixel_row) < 32'(MAX_HEIGHT));
         end
         ibs_pkg::OP_BILINEAR: begin
            entry_keep     = 1'b1;
            entry.col      = CMW'(x0_bil);
            entry.row      = CMW'(y0_bil);
            entry.frac_x   = FMW'(fx_bil);
            entry.frac_y   = FMW'(fy_bil);
            entry.col_last = x0_bil == last_col;
            entry.row_last = y0_bil == last_row;
            entry.in_range = 1'b1;
         end
         ibs_pkg::OP_NEAREST: begin
            entry_keep     = 1'b1;
            entry.col      = CMW'(x_near);
            entry.row      = CMW'(y_near);
            entry.col_last = 1'b1;
            entry.row_last = 1'b1;
            entry.in_range = near_x_ok && near_y_ok;
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/ibs_back.sv]
module ibs_back #(
   parameter int MAX_WIDTH  = ibs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ibs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = ibs_pkg::FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  ibs_pkg::entry_type                         head,
   input  logic                                       head_valid,
   input  logic [$clog2(ibs_pkg::OUT_DEPTH+1)-1:0]    out_level,
   output logic                                       head_pop,
   output logic                                       res_push,
   output ibs_pkg::rsp_type                           res
);

   localparam int F     = FRAC_BITS;
   localparam int OD    = ibs_pkg::OUT_DEPTH;
   localparam int LW    = $clog2(OD + 1);
   localparam int LW1   = LW + 1;
   localparam int RHW   = ((MAX_HEIGHT + 1) / 2 > 1) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
   localparam int CHW   = ((MAX_WIDTH + 1) / 2 > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
   localparam int BANK_DEPTH = 2 ** (RHW + CHW);
   localparam int ONE_W = F + 1;
   localparam int TOPW  = 8 + F;
   localparam int ACCW  = 8 + 2 * F;
   localparam int RW    = 8 + F;
   localparam int EW    = (RW > 16) ? RW : 17;
   localparam logic [ONE_W-1:0] ONE = {1'b1, {F{1'b0}}};

   logic           is_write, room;
   logic [LW1-1:0] occupancy;
   logic [RHW:0]   row_lo, row_hi;
   logic [CHW:0]   col_lo, col_hi;
   logic [7:0]     rd_ff [4];

   logic           b1_valid_ff, b1_valid_in;
   logic           b1_xp_ff, b1_yp_ff, b1_cl_ff, b1_rl_ff, b1_ir_ff;
   logic [F-1:0]   b1_fx_ff, b1_fy_ff;

   logic [7:0]       a0, a1, c0, c1, p00, p01, p10, p11;
   logic [ONE_W-1:0] wx0, wx1, wy0, wy1;
   logic [TOPW-1:0]  top_in, bot_in;

   logic             b2_valid_ff, b2_ir_ff;
   logic [F-1:0]     b2_fy_ff;
   logic [TOPW-1:0]  b2_top_ff, b2_bot_ff;

   logic [ACCW-1:0]  acc;
   logic [RW-1:0]    res_val;
   logic [EW-1:0]    res_e;
   logic [15:0]      res_sat;

   assign occupancy = LW1'(out_level) + LW1'(b1_valid_ff) + LW1'(b2_valid_ff);
   assign room      = occupancy < LW1'(OD);
   assign is_write  = head.kind == ibs_pkg::OP_WRITE;
   assign head_pop  = head_valid && (is_write || room);
   assign b1_valid_in = head_pop && !is_write;

   assign row_lo = head.row[RHW:0];
   assign row_hi = row_lo + 1'b1;
   assign col_lo = head.col[CHW:0];
   assign col_hi = col_lo + 1'b1;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic PR = 1'(b / 2);
      localparam logic PC = 1'(b % 2);

      logic [7:0]     mem [BANK_DEPTH];
      logic [RHW-1:0] r_addr;
      logic [CHW-1:0] c_addr;
      logic           we;

      assign r_addr = (row_lo[0] == PR) ? row_lo[RHW:1] : row_hi[RHW:1];
      assign c_addr = (col_lo[0] == PC) ? col_lo[CHW:1] : col_hi[CHW:1];
      assign we     = head_pop && is_write && head.store_hit &&
                      (row_lo[0] == PR) && (col_lo[0] == PC);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[{r_addr, c_addr}] <= head.value;
         end
         rd_ff[b] <= mem[{r_addr, c_addr}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_xp_ff  <= head.col[0];
      b1_yp_ff  <= head.row[0];
      b1_cl_ff  <= head.col_last;
      b1_rl_ff  <= head.row_last;
      b1_ir_ff  <= head.in_range;
      b1_fx_ff  <= head.frac_x[F-1:0];
      b1_fy_ff  <= head.frac_y[F-1:0];
      b2_ir_ff  <= b1_ir_ff;
      b2_fy_ff  <= b1_fy_ff;
      b2_top_ff <= top_in;
      b2_bot_ff <= bot_in;
   end

   always_comb begin
      a0  = b1_yp_ff ? rd_ff[2] : rd_ff[0];
      a1  = b1_yp_ff ? rd_ff[3] : rd_ff[1];
      c0  = b1_yp_ff ? rd_ff[0] : rd_ff[2];
      c1  = b1_yp_ff ? rd_ff[1] : rd_ff[3];
      p00 = b1_xp_ff ? a1 : a0;
      p01 = b1_cl_ff ? p00 : (b1_xp_ff ? a0 : a1);
      p10 = b1_rl_ff ? p00 : (b1_xp_ff ? c1 : c0);
      p11 = b1_rl_ff ? p01 : (b1_cl_ff ? p10 : (b1_xp_ff ? c0 : c1));
      wx1 = ONE_W'(b1_fx_ff);
      wx0 = ONE - wx1;
      top_in = TOPW'(p00) * TOPW'(wx0) + TOPW'(p01) * TOPW'(wx1);
      bot_in = TOPW'(p10) * TOPW'(wx0) + TOPW'(p11) * TOPW'(wx1);
   end

   always_comb begin
      wy1     = ONE_W'(b2_fy_ff);
      wy0     = ONE - wy1;
      acc     = ACCW'(b2_top_ff) * ACCW'(wy0) + ACCW'(b2_bot_ff) * ACCW'(wy1);
      res_val = acc[ACCW-1:F];
      res_e   = EW'(res_val);
      res_sat = (res_e > EW'(17'h0FFFF)) ? 16'hFFFF : res_e[15:0];
      res.sample_value = b2_ir_ff ? res_sat : '0;
      res.in_range     = b2_ir_ff;
   end

   assign res_push = b2_valid_ff;

endmodule

[hw/rtl/image_bilinear_sampler_unit.sv]
// Bilinear and nearest sampler over an 8-bit grayscale image held on chip. Push write beats
// (opcode 0) to load pixels at (pixel_row, pixel_col); pixels must be written before any
// sample reads them. A bilinear beat (opcode 1) clamps sample_x/sample_y (signed, FRAC_BITS
// fraction bits) to the image set by image_width/image_height and returns the blend of the
// four neighbours with FRAC_BITS fraction bits; a nearest beat (opcode 2) truncates toward
// zero and returns the pixel times 2^FRAC_BITS, or 0 with in_range low outside the image.
// Write beats and opcode 3 produce no result. The block takes one beat per cycle while full is
// low: the store is split into four single-port banks by row and column parity, so all four
// neighbours are read in the same cycle. A sample passes the input queue, bank read registers
// and horizontal blend registers, held in the queue while the output queue lacks room; the
// vertical blend feeds the output queue. Pixel writes take effect in order with samples. The
// configuration port is always ready; a width or height of 0 acts as 1 and values above the
// maximum act as the maximum. Reset leaves image contents undefined; no clearing pass is run.
`include "image_bilinear_sampler_unit_macros.svh"

module image_bilinear_sampler_unit #(
   parameter int MAX_WIDTH  = ibs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ibs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = ibs_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  ibs_pkg::req_type                   req_data,
   output logic                               full,
   input  logic                               pop,
   output ibs_pkg::rsp_type                   rsp_data,
   output logic                               empty,
   input  logic                               valid,
   output logic                               ready,
   input  logic [ibs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ibs_pkg::DIM_REG_W-1:0]      csr_data
);

   localparam int OLW = $clog2(ibs_pkg::OUT_DEPTH + 1);

   ibs_pkg::entry_type entry, head;
   ibs_pkg::rsp_type   res;
   logic               entry_keep, mid_push, mid_full, mid_empty, head_pop;
   logic               res_push, out_full, csr_write;
   logic [OLW-1:0]     out_level;

   assign ready     = 1'b1;
   assign csr_write = valid && ready;
   assign full      = mid_full;
   assign mid_push  = push && !mid_full && entry_keep;

   ibs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req        (req_data),
      .entry      (entry),
      .entry_keep (entry_keep)
   );

   ibs_fifo #(
      .WIDTH (($bits(ibs_pkg::entry_type))),
      .DEPTH (ibs_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (entry),
      .pop       (head_pop),
      .pop_data  (head),
      .full      (mid_full),
      .empty     (mid_empty),
      .level     ()
   );

   ibs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!mid_empty),
      .out_level  (out_level),
      .head_pop   (head_pop),
      .res_push   (res_push),
      .res        (res)
   );

   ibs_fifo #(
      .WIDTH (($bits(ibs_pkg::rsp_type))),
      .DEPTH (ibs_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .pop       (pop),
      .pop_data  (rsp_data),
      .full      (out_full),
      .empty     (empty),
      .level     (out_level)
   );

   `IBS_ASSERT_IMPLY(a_out_room, clock, reset, res_push, !out_full)
   `IBS_ASSERT_IMPLY(a_issue_origin, clock, reset, res_push, $past(head_pop && (head.kind != ibs_pkg::OP_WRITE), 2))
   `IBS_ASSERT_IMPLY(a_zero_outside, clock, reset, !empty && !rsp_data.in_range, rsp_data.sample_value == 16'd0)
   `IBS_ASSERT_NEXT(a_result_lands, clock, reset, res_push && !(pop && !empty), !empty)

endmodule
